/* rtl/srm_pkg.sv */
// Shared types and constants of the serial register access master.
// Used by srm_front, srm_back and the top level; depends on nothing.
package srm_pkg;

	// Input kind codes as they arrive on the kind port
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_WRITE = 3'd2;
	localparam logic [2:0] KIND_ENTER = 3'd3;
	localparam logic [2:0] KIND_LEAVE = 3'd4;
	localparam logic [2:0] KIND_SHUT  = 3'd5;

	// Low bits of the command byte
	localparam logic [1:0] OP_READ  = 2'b01;
	localparam logic [1:0] OP_WRITE = 2'b10;

	// Dummy byte sent after a read command
	localparam logic [7:0] RD_DUMMY = 8'hFF;

	// Configuration register indexes and reset value
	localparam logic       REG_PHASE_DELAY   = 1'b0;
	localparam logic [23:0] PHASE_DELAY_RESET = 24'd50000;

	// Depth of the queues on both sides of the sequencer
	localparam int unsigned Q_DEPTH = 2;

	// Command class decided by the front end
	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_READ,
		CMD_WRITE,
		CMD_ENTER,
		CMD_LEAVE,
		CMD_SHUT
	} cmd_e_t;

	// One classified beat handed from front to back
	typedef struct packed {
		cmd_e_t      cmd;
		logic [7:0]  cmd_byte;
		logic [31:0] wdata;
		logic [1:0]  rd_last;
		logic        miso;
	} item_t;

	// One result beat
	typedef struct packed {
		logic        sel;
		logic        ej;
		logic        mode;
		logic        mosi;
		logic        clk_pulse;
		logic        busy;
		logic        done;
		logic [31:0] word;
		logic        rejected;
	} res_t;

endpackage

/* rtl/srm_fifo.sv */
// Small register queue with push/pop handshake.
// Generic; used by srm_front and srm_back.
module srm_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/srm_front.sv */
// Front end: classifies each input beat and queues it for the sequencer.
// Depends on srm_pkg and srm_fifo.
module srm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    kind,
	input  logic [5:0]    reg_index,
	input  logic [31:0]   write_word,
	input  logic [2:0]    read_bytes,
	input  logic          miso,
	input  logic          item_pop,
	output srm_pkg::item_t item,
	output logic          item_empty
);
	import srm_pkg::*;

	item_t             dec;
	logic [$bits(item_t)-1:0] head;

	// Decode the kind and clamp the read length
	always_comb begin
		dec.wdata = write_word;
		dec.miso  = miso;
		unique case (kind)
			KIND_READ:  dec.cmd = CMD_READ;
			KIND_WRITE: dec.cmd = CMD_WRITE;
			KIND_ENTER: dec.cmd = CMD_ENTER;
			KIND_LEAVE: dec.cmd = CMD_LEAVE;
			KIND_SHUT:  dec.cmd = CMD_SHUT;
			default:    dec.cmd = CMD_TICK;
		endcase
		dec.cmd_byte = {reg_index, (kind == KIND_WRITE) ? OP_WRITE : OP_READ};
		if (read_bytes == 3'd0) begin
			dec.rd_last = 2'd0;
		end else if (read_bytes > 3'd4) begin
			dec.rd_last = 2'd3;
		end else begin
			dec.rd_last = 2'(read_bytes - 3'd1);
		end
	end

	srm_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(Q_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(dec),
		.full   (full),
		.pop    (item_pop),
		.rd_data(head),
		.empty  (item_empty)
	);

	assign item = item_t'(head);

endmodule

/* rtl/srm_back.sv */
// Back end: bit-period sequencer that drives the pins, plus the result queue.
// Depends on srm_pkg and srm_fifo.
module srm_back #(
	parameter int unsigned DATA_BYTES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [23:0]    dly_load,
	input  srm_pkg::item_t item,
	input  logic           item_empty,
	output logic           item_pop,
	input  logic           pop,
	output logic           empty,
	output srm_pkg::res_t  res_out
);
	import srm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RD_SEND,
		PH_FETCH,
		PH_WR_CMD,
		PH_PUT,
		PH_SHUT,
		PH_LEAVE,
		PH_ENTER1,
		PH_ENTER2,
		PH_ENTER3
	} phase_t;

	localparam logic [2:0] DATA_LAST = 3'(DATA_BYTES - 1);

	phase_t      phase_q, ph;
	logic [4:0]  bit_cnt_q, bc;
	logic [31:0] out_sh_q, osh;
	logic [31:0] in_g_q, ig;
	logic [23:0] wait_q, wc;
	logic [2:0]  fetch_q, fc;
	logic        sel_q, ej_q, mode_q, mosi_q;
	logic        sel, ej, mode, mosi;
	res_t        res;
	logic        rq_full, fire;
	logic [$bits(res_t)-1:0] rq_head;

	assign fire     = !item_empty && !rq_full;
	assign item_pop = fire;

	// Work out one bit period
	always_comb begin
		ph   = phase_q;
		bc   = bit_cnt_q;
		osh  = out_sh_q;
		ig   = in_g_q;
		wc   = wait_q;
		fc   = fetch_q;
		sel  = sel_q;
		ej   = ej_q;
		mode = mode_q;
		mosi = mosi_q;
		res  = '0;

		// Start a command, or flag it when one is running
		if (item.cmd != CMD_TICK) begin
			if (phase_q != PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				bc = '0;
				unique case (item.cmd)
					CMD_READ: begin
						sel = 1'b0;
						osh = {16'h0, RD_DUMMY, item.cmd_byte};
						ig  = '0;
						fc  = 3'd1;
						wc  = {22'h0, item.rd_last};
						ph  = PH_RD_SEND;
					end
					CMD_WRITE: begin
						sel = 1'b0;
						osh = {24'h0, item.cmd_byte};
						ig  = item.wdata;
						fc  = 3'd0;
						ph  = PH_WR_CMD;
					end
					CMD_ENTER: begin
						mode = 1'b0;
						wc   = dly_load;
						ph   = PH_ENTER1;
					end
					CMD_LEAVE: begin
						sel = 1'b1;
						ej  = 1'b0;
						wc  = dly_load;
						ph  = PH_LEAVE;
					end
					CMD_SHUT: begin
						sel  = 1'b1;
						mode = 1'b0;
						ej   = 1'b0;
						wc   = dly_load;
						ph   = PH_SHUT;
					end
					default: ;
				endcase
			end
		end

		// Drive the data line and clock for this period
		if (ph == PH_RD_SEND || ph == PH_WR_CMD || ph == PH_PUT) begin
			mosi          = osh[0];
			res.clk_pulse = 1'b1;
		end else if (ph == PH_FETCH) begin
			mosi          = 1'b0;
			res.clk_pulse = 1'b1;
		end
		res.sel  = sel;
		res.ej   = ej;
		res.mode = mode;
		res.mosi = mosi;

		// Advance the sequence
		unique case (ph)
			PH_RD_SEND, PH_WR_CMD, PH_PUT: begin
				osh = osh >> 1;
				if (bc < 5'd7) begin
					bc = bc + 5'd1;
				end else begin
					bc = '0;
					if (fc != 3'd0) begin
						fc = fc - 3'd1;
					end else if (ph == PH_RD_SEND) begin
						fc = {1'b0, wc[1:0]};
						wc = '0;
						ph = PH_FETCH;
					end else if (ph == PH_WR_CMD) begin
						osh = ig;
						fc  = DATA_LAST;
						ph  = PH_PUT;
					end else begin
						sel      = 1'b1;
						ph       = PH_IDLE;
						res.done = 1'b1;
					end
				end
			end
			PH_FETCH: begin
				ig[bc] = ig[bc] | item.miso;
				if ({1'b0, bc} >= {fc, 3'b111}) begin
					res.word = ig;
					bc       = '0;
					sel      = 1'b1;
					ph       = PH_IDLE;
					res.done = 1'b1;
				end else begin
					bc = bc + 5'd1;
				end
			end
			PH_SHUT, PH_LEAVE, PH_ENTER1, PH_ENTER2, PH_ENTER3: begin
				if (wc != '0) begin
					wc = wc - 24'd1;
				end else begin
					unique case (ph)
						PH_SHUT: begin
							ej       = 1'b1;
							ph       = PH_IDLE;
							res.done = 1'b1;
						end
						PH_LEAVE: begin
							mode     = 1'b0;
							ej       = 1'b1;
							ph       = PH_IDLE;
							res.done = 1'b1;
						end
						PH_ENTER1: begin
							sel = 1'b0;
							ej  = 1'b0;
							wc  = dly_load;
							ph  = PH_ENTER2;
						end
						PH_ENTER2: begin
							mode = 1'b1;
							ej   = 1'b1;
							wc   = dly_load;
							ph   = PH_ENTER3;
						end
						default: begin
							ph       = PH_IDLE;
							res.done = 1'b1;
						end
					endcase
				end
			end
			default: ph = PH_IDLE;
		endcase

		res.busy = (ph != PH_IDLE);
	end

	// Hold sequencer state; advance once per beat taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			out_sh_q  <= '0;
			in_g_q    <= '0;
			wait_q    <= '0;
			fetch_q   <= '0;
			sel_q     <= 1'b1;
			ej_q      <= 1'b1;
			mode_q    <= 1'b1;
			mosi_q    <= 1'b0;
		end else if (fire) begin
			phase_q   <= ph;
			bit_cnt_q <= bc;
			out_sh_q  <= osh;
			in_g_q    <= ig;
			wait_q    <= wc;
			fetch_q   <= fc;
			sel_q     <= sel;
			ej_q      <= ej;
			mode_q    <= mode;
			mosi_q    <= mosi;
		end
	end

	srm_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.wr_data(res),
		.full   (rq_full),
		.pop    (pop),
		.rd_data(rq_head),
		.empty  (empty)
	);

	assign res_out = res_t'(rq_head);

	// A finished operation never reports busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done |-> !res.busy)
		else $error("done beat still busy");

	// A clock pulse only happens with select low
	a_clk_sel: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.clk_pulse |-> !res.sel)
		else $error("serial clock with select high");

	// Read data shows only on the finishing beat
	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.word != '0) |-> res.done)
		else $error("read word outside done beat");

	// A beat that ends an operation leaves the sequencer idle
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done |=> phase_q == PH_IDLE)
		else $error("sequencer not idle after done");

endmodule

/* rtl/serial_register_access_master_unit.sv */
// Serial register access master (LSB first) with select, eject and mode pin
// sequencing. Every input beat is one serial bit period and yields exactly one
// result beat. The unit takes one beat per clock while results are popped: a
// two-entry command queue feeds a sequencer that advances one bit period per
// beat taken, and a two-entry result queue absorbs consumer stalls until both
// queues fill and full holds back the input side. A beat is registered in the
// command queue, then its result in the result queue, before it can be popped.
// Register 0 (byte address 0) holds the 24-bit phase delay in ticks; zero
// acts as one. Write it only while the unit is idle.
// Top level; depends on srm_pkg, srm_front and srm_back.
module serial_register_access_master_unit #(
	parameter int unsigned DATA_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input beats
	input  logic        push,
	output logic        full,
	input  logic [2:0]  kind,
	input  logic [5:0]  reg_index,
	input  logic [31:0] write_word,
	input  logic [2:0]  read_bytes,
	input  logic        miso,
	// result beats
	input  logic        pop,
	output logic        empty,
	output logic        select_level,
	output logic        eject_level,
	output logic        mode_level,
	output logic        mosi_level,
	output logic        clock_pulse,
	output logic        busy_res,
	output logic        done_res,
	output logic [31:0] read_word,
	output logic        rejected
);
	import srm_pkg::*;

	logic [23:0] dly_q;
	logic [23:0] dly_load_q;
	logic        cfg_wr;
	item_t       item;
	logic        item_empty, item_pop;
	res_t        res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Hold the phase delay and its preloaded counter value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q      <= PHASE_DELAY_RESET;
			dly_load_q <= PHASE_DELAY_RESET - 24'd1;
		end else if (cfg_wr && paddr[2] == REG_PHASE_DELAY) begin
			dly_q      <= pwdata[23:0];
			dly_load_q <= (pwdata[23:0] == '0) ? '0 : pwdata[23:0] - 24'd1;
		end
	end

	// Read back the register
	assign prdata = (paddr[2] == REG_PHASE_DELAY) ? {8'h0, dly_q} : '0;

	srm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.reg_index (reg_index),
		.write_word(write_word),
		.read_bytes(read_bytes),
		.miso      (miso),
		.item_pop  (item_pop),
		.item      (item),
		.item_empty(item_empty)
	);

	srm_back #(
		.DATA_BYTES(DATA_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dly_load  (dly_load_q),
		.item      (item),
		.item_empty(item_empty),
		.item_pop  (item_pop),
		.pop       (pop),
		.empty     (empty),
		.res_out   (res)
	);

	assign select_level = res.sel;
	assign eject_level  = res.ej;
	assign mode_level   = res.mode;
	assign mosi_level   = res.mosi;
	assign clock_pulse  = res.clk_pulse;
	assign busy_res     = res.busy;
	assign done_res     = res.done;
	assign read_word    = res.word;
	assign rejected     = res.rejected;

endmodule

/* dv/tb_serial_register_access_master_unit.sv */
`timescale 1ns / 1ps
// Testbench for serial_register_access_master_unit: directed and random bit-period beats,
// each result checked against an in-bench model of the serial master and pin sequencer.
// Depends on srm_pkg and the RTL of the unit.
module tb_serial_register_access_master_unit;
	import srm_pkg::*;

	localparam int unsigned DATA_BYTES = 4;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned BEAT_GOAL = 1700;
	localparam logic [2:0] DELAY_ADDR = 3'(4 * REG_PHASE_DELAY);

	// Kind codes the package leaves out: plain tick and the two undefined ones
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	// Data-in line pattern while a read is fetching
	localparam int MISO_LOW  = 0;
	localparam int MISO_HIGH = 1;
	localparam int MISO_RAND = 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_SEND, ST_FETCH, ST_WR_CMD, ST_PUT,
		ST_SHUT, ST_LEAVE, ST_ENTER1, ST_ENTER2, ST_ENTER3
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  kind = '0;
	logic [5:0]  reg_index = '0;
	logic [31:0] write_word = '0;
	logic [2:0]  read_bytes = '0;
	logic        miso = 1'b0;
	logic        pop = 1'b0;
	logic        empty;
	logic        select_level;
	logic        eject_level;
	logic        mode_level;
	logic        mosi_level;
	logic        clock_pulse;
	logic        busy_res;
	logic        done_res;
	logic [31:0] read_word;
	logic        rejected;

	// Model state of the sequencer and the pins
	seq_state_t  seq_st = ST_IDLE;
	logic [5:0]  bit_cnt = '0;
	logic [31:0] sr_out = '0;
	logic [31:0] gather_word = '0;
	logic [23:0] hold_cnt = '0;
	logic [2:0]  byte_left = '0;
	logic        pin_sel = 1'b1;
	logic        pin_ej = 1'b1;
	logic        pin_mode = 1'b1;
	logic        pin_data = 1'b0;
	logic [23:0] phase_delay = PHASE_DELAY_RESET;

	res_t        tick_results_q[$];
	res_t        got_res;
	res_t        want_res;
	int unsigned fault_cnt = 0;
	int unsigned beat_cnt = 0;
	int unsigned stall_cycles = 0;
	bit          gaps_on = 1'b1;

	serial_register_access_master_unit #(.DATA_BYTES(DATA_BYTES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .kind(kind), .reg_index(reg_index),
		.write_word(write_word), .read_bytes(read_bytes), .miso(miso),
		.pop(pop), .empty(empty), .select_level(select_level),
		.eject_level(eject_level), .mode_level(mode_level), .mosi_level(mosi_level),
		.clock_pulse(clock_pulse), .busy_res(busy_res), .done_res(done_res),
		.read_word(read_word), .rejected(rejected)
	);

	always #5 clk = ~clk;

	function automatic logic [23:0] delay_reload();
		return (phase_delay == 24'd0) ? 24'd0 : phase_delay - 24'd1;
	endfunction

	// Advance the model by one bit period and return the pins and status it shows
	function automatic res_t advance_bus_tick(input logic [2:0] k, input logic [5:0] idx,
			input logic [31:0] wd, input logic [2:0] rb, input logic mi);
		res_t       r;
		logic [2:0] nbytes;
		r = '0;

		// Start a command when idle, flag it when busy
		if (k >= KIND_READ && k <= KIND_SHUT) begin
			if (seq_st != ST_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				nbytes = (rb == 3'd0) ? 3'd1 : ((rb > 3'd4) ? 3'd4 : rb);
				bit_cnt = '0;
				case (k)
					KIND_READ: begin
						pin_sel = 1'b0;
						sr_out = {16'h0, RD_DUMMY, idx, OP_READ};
						gather_word = '0;
						byte_left = 3'd1;
						hold_cnt = 24'(nbytes - 3'd1);
						seq_st = ST_RD_SEND;
					end
					KIND_WRITE: begin
						pin_sel = 1'b0;
						sr_out = {24'h0, idx, OP_WRITE};
						gather_word = wd;
						byte_left = 3'd0;
						seq_st = ST_WR_CMD;
					end
					KIND_ENTER: begin
						pin_mode = 1'b0;
						hold_cnt = delay_reload();
						seq_st = ST_ENTER1;
					end
					KIND_LEAVE: begin
						pin_sel = 1'b1;
						pin_ej = 1'b0;
						hold_cnt = delay_reload();
						seq_st = ST_LEAVE;
					end
					default: begin
						pin_sel = 1'b1;
						pin_mode = 1'b0;
						pin_ej = 1'b0;
						hold_cnt = delay_reload();
						seq_st = ST_SHUT;
					end
				endcase
			end
		end

		// Drive the data line and the serial clock for this period
		if (seq_st == ST_RD_SEND || seq_st == ST_WR_CMD || seq_st == ST_PUT) begin
			pin_data = sr_out[0];
			r.clk_pulse = 1'b1;
		end else if (seq_st == ST_FETCH) begin
			pin_data = 1'b0;
			r.clk_pulse = 1'b1;
		end
		r.sel = pin_sel;
		r.ej = pin_ej;
		r.mode = pin_mode;
		r.mosi = pin_data;

		case (seq_st)
			ST_RD_SEND, ST_WR_CMD, ST_PUT: begin
				sr_out = sr_out >> 1;
				if (bit_cnt < 6'd7) begin
					bit_cnt = bit_cnt + 6'd1;
				end else begin
					bit_cnt = '0;
					if (byte_left != 3'd0) begin
						byte_left = byte_left - 3'd1;
					end else if (seq_st == ST_RD_SEND) begin
						byte_left = {1'b0, hold_cnt[1:0]};
						hold_cnt = '0;
						seq_st = ST_FETCH;
					end else if (seq_st == ST_WR_CMD) begin
						sr_out = gather_word;
						byte_left = 3'((DATA_BYTES - 1) & 7);
						seq_st = ST_PUT;
					end else begin
						pin_sel = 1'b1;
						seq_st = ST_IDLE;
						r.done = 1'b1;
					end
				end
			end
			ST_FETCH: begin
				gather_word = gather_word | (32'(mi) << bit_cnt[4:0]);
				if (int'(bit_cnt) >= int'(byte_left) * 8 + 7) begin
					r.word = gather_word;
					bit_cnt = '0;
					pin_sel = 1'b1;
					seq_st = ST_IDLE;
					r.done = 1'b1;
				end else begin
					bit_cnt = bit_cnt + 6'd1;
				end
			end
			ST_SHUT, ST_LEAVE, ST_ENTER1, ST_ENTER2, ST_ENTER3: begin
				if (hold_cnt != 24'd0) begin
					hold_cnt = hold_cnt - 24'd1;
				end else begin
					case (seq_st)
						ST_SHUT: begin
							pin_ej = 1'b1;
							seq_st = ST_IDLE;
							r.done = 1'b1;
						end
						ST_LEAVE: begin
							pin_mode = 1'b0;
							pin_ej = 1'b1;
							seq_st = ST_IDLE;
							r.done = 1'b1;
						end
						ST_ENTER1: begin
							pin_sel = 1'b0;
							pin_ej = 1'b0;
							hold_cnt = delay_reload();
							seq_st = ST_ENTER2;
						end
						ST_ENTER2: begin
							pin_mode = 1'b1;
							pin_ej = 1'b1;
							hold_cnt = delay_reload();
							seq_st = ST_ENTER3;
						end
						default: begin
							seq_st = ST_IDLE;
							r.done = 1'b1;
						end
					endcase
				end
			end
			default: seq_st = ST_IDLE;
		endcase
		r.busy = (seq_st != ST_IDLE);
		return r;
	endfunction

	function automatic string fmt_res(input res_t r);
		return $sformatf("sel=%b ej=%b mode=%b mosi=%b clk=%b busy=%b done=%b word=%h rej=%b",
			r.sel, r.ej, r.mode, r.mosi, r.clk_pulse, r.busy, r.done, r.word, r.rejected);
	endfunction

	// Send one bit-period beat and record what it must produce
	task automatic send_tick(input logic [2:0] k, input logic [5:0] idx, input logic [31:0] wd,
			input logic [2:0] rb, input logic mi);
		res_t r;
		if (gaps_on && $urandom_range(0, 99) < 7) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		reg_index <= idx;
		write_word <= wd;
		read_bytes <= rb;
		miso <= mi;
		@(posedge clk);
		while (full) @(posedge clk);
		r = advance_bus_tick(k, idx, wd, rb, mi);
		tick_results_q.push_back(r);
		beat_cnt++;
	endtask

	// Tick with random filler until the current operation ends
	task automatic pump_until_idle(input int miso_pat, input int noise_pct);
		logic mi;
		logic [2:0] k;
		while (seq_st != ST_IDLE) begin
			mi = (miso_pat == MISO_RAND) ? 1'($urandom) : (miso_pat == MISO_HIGH);
			if ($urandom_range(0, 99) < noise_pct)
				k = 3'($urandom_range(1, 7));
			else
				k = ($urandom_range(0, 19) == 0) ? KIND_RSVD6 + 3'($urandom_range(0, 1))
					: KIND_TICK;
			send_tick(k, 6'($urandom), $urandom, 3'($urandom), mi);
		end
	endtask

	task automatic run_op(input logic [2:0] k, input logic [5:0] idx, input logic [31:0] wd,
			input logic [2:0] rb, input int miso_pat, input int noise_pct);
		send_tick(k, idx, wd, rb, 1'($urandom));
		pump_until_idle(miso_pat, noise_pct);
	endtask

	// Hold input and wait until every beat has come out
	task automatic drain_results();
		push <= 1'b0;
		while (tick_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdat,
			output logic [31:0] rdat);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdat;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdat = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_delay(input logic [23:0] val);
		logic [31:0] unused;
		drain_results();
		apb_access(1'b1, DELAY_ADDR, {8'h0, val}, unused);
		phase_delay = val;
	endtask

	task automatic check_delay_reg();
		logic [31:0] rd;
		apb_access(1'b0, DELAY_ADDR, '0, rd);
		if (rd[23:0] !== phase_delay) begin
			if (fault_cnt < 10)
				$display("delay register: exp %h act %h", phase_delay, rd[23:0]);
			fault_cnt++;
		end
	endtask

	// Check each popped beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			got_res = {select_level, eject_level, mode_level, mosi_level, clock_pulse,
				busy_res, done_res, read_word, rejected};
			if (tick_results_q.size() == 0) begin
				if (fault_cnt < 10) $display("unexpected beat: %s", fmt_res(got_res));
				fault_cnt++;
			end else begin
				want_res = tick_results_q.pop_front();
				if (got_res !== want_res) begin
					if (fault_cnt < 10) begin
						$display("mismatch exp: %s", fmt_res(want_res));
						$display("         act: %s", fmt_res(got_res));
					end
					fault_cnt++;
				end
			end
		end
		pop <= !(gaps_on && $urandom_range(0, 99) < 7);
	end

	// Abort when no beat or bus access moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", stall_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_delay_register();
		check_delay_reg();
		set_delay(24'hFFFFFF);
		check_delay_reg();
		set_delay(24'd0);
		check_delay_reg();
	endtask

	// Zero delay acts as one, then one and a few ticks per phase
	task automatic test_timed_ops();
		run_op(KIND_ENTER, '0, '0, '0, MISO_RAND, 0);
		run_op(KIND_LEAVE, '0, '0, '0, MISO_RAND, 0);
		run_op(KIND_SHUT, '0, '0, '0, MISO_RAND, 0);
		set_delay(24'd1);
		run_op(KIND_SHUT, '0, '0, '0, MISO_RAND, 0);
		run_op(KIND_ENTER, '0, '0, '0, MISO_RAND, 0);
		run_op(KIND_LEAVE, '0, '0, '0, MISO_RAND, 0);
		set_delay(24'd3);
		run_op(KIND_ENTER, '0, '0, '0, MISO_RAND, 0);
	endtask

	// Byte counts in and out of range, data line stuck high and low
	task automatic test_reads();
		run_op(KIND_READ, 6'd0, '0, 3'd1, MISO_HIGH, 0);
		run_op(KIND_READ, 6'd63, '1, 3'd4, MISO_HIGH, 0);
		run_op(KIND_READ, 6'd42, '0, 3'd0, MISO_LOW, 0);
		run_op(KIND_READ, 6'd21, '0, 3'd5, MISO_RAND, 0);
		run_op(KIND_READ, 6'd7, '0, 3'd7, MISO_RAND, 0);
		run_op(KIND_READ, 6'd3, '0, 3'd2, MISO_RAND, 0);
		run_op(KIND_READ, 6'd56, '0, 3'd3, MISO_RAND, 0);
	endtask

	task automatic test_writes();
		run_op(KIND_WRITE, 6'd0, 32'h0000_0000, 3'd0, MISO_RAND, 0);
		run_op(KIND_WRITE, 6'd63, 32'hFFFF_FFFF, 3'd7, MISO_RAND, 0);
		run_op(KIND_WRITE, 6'd21, 32'hA5A5_A5A5, 3'd1, MISO_RAND, 0);
		run_op(KIND_WRITE, 6'd42, 32'h5A5A_5A5A, 3'd4, MISO_RAND, 0);
	endtask

	// Every command kind while a read and then a timed phase is running
	task automatic test_busy_commands();
		logic [2:0] k;
		send_tick(KIND_READ, 6'd9, '0, 3'd2, 1'b1);
		for (int i = 1; i < 8; i++) begin
			k = 3'(i);
			send_tick(k, 6'($urandom), $urandom, 3'($urandom), 1'($urandom));
		end
		pump_until_idle(MISO_RAND, 0);
		send_tick(KIND_ENTER, '0, '0, '0, 1'b0);
		for (int i = 1; i < 8; i++) begin
			k = 3'(i);
			send_tick(k, 6'($urandom), $urandom, 3'($urandom), 1'($urandom));
		end
		pump_until_idle(MISO_RAND, 0);
		send_tick(KIND_RSVD6, '1, '1, '1, 1'b1);
		send_tick(KIND_RSVD7, '0, '0, '0, 1'b0);
	endtask

	// Random operations until the whole run has sent its share of beats
	task automatic test_random_traffic();
		int unsigned goal;
		int unsigned sel;
		int unsigned round;
		logic [2:0] k;
		goal = BEAT_GOAL;
		round = 0;
		while (beat_cnt < goal) begin
			// New delay per round, mostly short, sometimes zero or longer
			sel = $urandom_range(0, 9);
			set_delay(sel == 0 ? 24'd0 : (sel == 1 ? 24'($urandom_range(10, 30))
				: 24'($urandom_range(1, 5))));
			gaps_on = (round != 1);
			for (int n = 0; n < 12 && beat_cnt < goal; n++) begin
				// Idle filler between operations
				if ($urandom_range(0, 4) == 0) begin
					k = ($urandom_range(0, 1) == 0) ? KIND_TICK
						: KIND_RSVD6 + 3'($urandom_range(0, 1));
					send_tick(k, 6'($urandom), $urandom, 3'($urandom), 1'($urandom));
				end
				sel = $urandom_range(0, 99);
				if (sel < 40)
					k = KIND_READ;
				else if (sel < 75)
					k = KIND_WRITE;
				else if (sel < 83)
					k = KIND_ENTER;
				else if (sel < 91)
					k = KIND_LEAVE;
				else
					k = KIND_SHUT;
				run_op(k, 6'($urandom), $urandom, 3'($urandom), MISO_RAND, 4);
			end
			round++;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_delay_register();
		test_timed_ops();
		test_reads();
		test_writes();
		test_busy_commands();
		test_random_traffic();
		drain_results();
		if (tick_results_q.size() != 0) fault_cnt++;
		if (fault_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
